// ===== src/kfsc_pkg.sv =====
// shared types and constants for the k-frequency substring counter
// no dependencies; used by every module of the block

package kfsc_pkg;

   localparam int SYMBOL_W   = 8;
   localparam int CNT_W      = 5;
   localparam int K_W        = 5;
   localparam int ENDING_W   = 32;
   localparam int TOTAL_W    = 48;
   localparam int RSP_DATA_W = ENDING_W + TOTAL_W;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;
   localparam logic [K_W-1:0]   K_RESET = K_W'(2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_COUNT,
      ST_DROP_RD,
      ST_DROP_WR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } cnt_cmd_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ring_cmd_type;

endpackage

// ===== src/k_frequency_substring_counter.sv =====
// Counts, per incoming byte, the substrings ending there in which some symbol
// occurs at least k times, plus a saturating running total for the string. One
// request is worked at a time and yields one response. A request steps through
// push, count, a read and a write step per window symbol it drops, and finish;
// a window ring that is full on arrival first costs one drop and a second push.
// Each step makes at most one access to the count memory, which the counts use
// for read-modify-write. A response can wait in the output register while the
// next request is already accepted. A request with the start flag restarts the
// string at once: counts clear through per-entry valid bits, so there is no clearing pass after reset or start.
// Depends on kfsc_pkg, kfsc_count_store and kfsc_window_ring.

module k_frequency_substring_counter #(
   parameter int SYMBOLS      = 256,
   parameter int WINDOW_DEPTH = 4096,
   parameter int K_MAX        = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [kfsc_pkg::SYMBOL_W-1:0]       req_tdata,  // [7:0] symbol
   input  logic                                req_tuser,  // [0] string_start
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [kfsc_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [31:0] valid_ending_here,
                                                           // [79:32] running_total
   // threshold register
   input  logic                                csr_wr_en,
   input  logic [kfsc_pkg::K_W-1:0]            csr_wr_data // [4:0] k_threshold
);

   localparam int SYM_W  = $clog2(SYMBOLS);
   localparam int WIN_W  = $clog2(WINDOW_DEPTH);
   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int CNT_W  = kfsc_pkg::CNT_W;
   localparam int K_W    = kfsc_pkg::K_W;
   localparam int END_W  = kfsc_pkg::ENDING_W;
   localparam int TOT_W  = kfsc_pkg::TOTAL_W;

   localparam logic [K_W-1:0]    K_LIMIT  = K_W'(K_MAX);
   localparam logic [WIN_W-1:0]  WIN_LAST = WIN_W'(WINDOW_DEPTH - 1);
   localparam logic [FILL_W-1:0] WIN_FULL = FILL_W'(WINDOW_DEPTH);

   kfsc_pkg::state_type state_ff, state_in;

   logic [SYM_W-1:0]                  sym_ff, sym_in;
   logic                              pre_ff, pre_in;
   logic [CNT_W-1:0]                  cur_cnt_ff, cur_cnt_in;
   logic [WIN_W-1:0]                  head_ff, head_in;
   logic [WIN_W-1:0]                  tail_ff, tail_in;
   logic [FILL_W-1:0]                 fill_ff, fill_in;
   logic [END_W-1:0]                  dropped_ff, dropped_in;
   logic [TOT_W-1:0]                  total_ff, total_in;
   logic [K_W-1:0]                    k_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [kfsc_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [SYM_W-1:0] fold_tbl [1 << kfsc_pkg::SYMBOL_W];

   kfsc_pkg::cnt_cmd_type  cnt_cmd;
   kfsc_pkg::ring_cmd_type ring_cmd;
   logic [SYM_W-1:0]       cnt_rd_addr, cnt_wr_addr;
   logic [CNT_W-1:0]       cnt_wr_data, cnt_q;
   logic [WIN_W-1:0]       ring_rd_addr;
   logic [SYM_W-1:0]       ring_q;

   logic                 req_fire, rsp_free, ring_full;
   logic [K_W-1:0]       k_eff;
   logic [CNT_W-1:0]     cnt_inc, cnt_dec, drop_cur;
   logic [WIN_W-1:0]     head_nx, tail_nx;
   logic [FILL_W-1:0]    fill_dec;
   logic                 more_after_push, more_after_drop;
   logic [TOT_W:0]       total_sum;
   logic [TOT_W-1:0]     total_sat;
   logic [END_W-1:0]     dropped_inc;

   // symbols at or above SYMBOLS fold back; the table is built at elaboration
   for (genvar i = 0; i < (1 << kfsc_pkg::SYMBOL_W); i++) begin : g_fold
      assign fold_tbl[i] = SYM_W'(i % SYMBOLS);
   end

   kfsc_count_store #(
      .SYMBOLS (SYMBOLS)
   ) u_count_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cnt_cmd),
      .rd_addr (cnt_rd_addr),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_data (cnt_q)
   );

   kfsc_window_ring #(
      .SYMBOLS      (SYMBOLS),
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_window_ring (
      .clock   (clock),
      .cmd     (ring_cmd),
      .rd_addr (ring_rd_addr),
      .wr_addr (tail_ff),
      .wr_data (sym_ff),
      .rd_data (ring_q)
   );

   assign req_tready = (state_ff == kfsc_pkg::ST_IDLE) && !reset;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign k_eff = (k_ff == '0) ? K_W'(1) : ((k_ff > K_LIMIT) ? K_LIMIT : k_ff);

   assign ring_full = (fill_ff == WIN_FULL);
   assign cnt_inc   = (cnt_q == kfsc_pkg::CNT_MAX) ? cnt_q : cnt_q + CNT_W'(1);
   assign cnt_dec   = (cnt_q == '0) ? cnt_q : cnt_q - CNT_W'(1);
   assign head_nx   = (head_ff == WIN_LAST) ? '0 : head_ff + WIN_W'(1);
   assign tail_nx   = (tail_ff == WIN_LAST) ? '0 : tail_ff + WIN_W'(1);
   assign fill_dec  = fill_ff - FILL_W'(1);

   // the dropped symbol may equal the one just pushed, then its count follows
   assign drop_cur        = (ring_q == sym_ff) ? cnt_dec : cur_cnt_ff;
   assign more_after_push = (cnt_inc >= k_eff);
   assign more_after_drop = (drop_cur >= k_eff) && (fill_dec != '0);

   assign dropped_inc = (dropped_ff == '1) ? dropped_ff : dropped_ff + END_W'(1);
   assign total_sum   = {1'b0, total_ff} + (TOT_W + 1)'(dropped_ff);
   assign total_sat   = total_sum[TOT_W] ? '1 : total_sum[TOT_W-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kfsc_pkg::ST_IDLE: begin
            if (req_fire) state_in = kfsc_pkg::ST_PUSH;
         end
         kfsc_pkg::ST_PUSH: begin
            state_in = ring_full ? kfsc_pkg::ST_DROP_RD : kfsc_pkg::ST_COUNT;
         end
         kfsc_pkg::ST_COUNT: begin
            state_in = more_after_push ? kfsc_pkg::ST_DROP_RD : kfsc_pkg::ST_FINISH;
         end
         kfsc_pkg::ST_DROP_RD: begin
            state_in = kfsc_pkg::ST_DROP_WR;
         end
         kfsc_pkg::ST_DROP_WR: begin
            if (pre_ff) begin
               state_in = kfsc_pkg::ST_PUSH;
            end else if (more_after_drop) begin
               state_in = kfsc_pkg::ST_DROP_RD;
            end else begin
               state_in = kfsc_pkg::ST_FINISH;
            end
         end
         kfsc_pkg::ST_FINISH: begin
            if (rsp_free) state_in = kfsc_pkg::ST_IDLE;
         end
         default: begin
            state_in = kfsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      sym_in       = sym_ff;
      pre_in       = pre_ff;
      cur_cnt_in   = cur_cnt_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      dropped_in   = dropped_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      cnt_cmd      = '0;
      ring_cmd     = '0;
      cnt_rd_addr  = sym_ff;
      cnt_wr_addr  = sym_ff;
      cnt_wr_data  = cnt_inc;
      ring_rd_addr = head_ff;
      case (state_ff)
         kfsc_pkg::ST_IDLE: begin
            if (req_fire) begin
               sym_in = fold_tbl[req_tdata];
               if (req_tuser) begin
                  head_in       = '0;
                  tail_in       = '0;
                  fill_in       = '0;
                  dropped_in    = '0;
                  total_in      = '0;
                  cnt_cmd.clear = 1'b1;
               end
            end
         end
         kfsc_pkg::ST_PUSH: begin
            if (ring_full) begin
               // make room first: the oldest symbol leaves the window
               ring_cmd.rd_en = 1'b1;
               pre_in         = 1'b1;
            end else begin
               ring_cmd.wr_en = 1'b1;
               tail_in        = tail_nx;
               fill_in        = fill_ff + FILL_W'(1);
               cnt_cmd.rd_en  = 1'b1;
            end
         end
         kfsc_pkg::ST_COUNT: begin
            cnt_cmd.wr_en = 1'b1;
            cur_cnt_in    = cnt_inc;
            pre_in        = 1'b0;
            if (more_after_push) begin
               ring_cmd.rd_en = 1'b1;
            end
         end
         kfsc_pkg::ST_DROP_RD: begin
            cnt_cmd.rd_en = 1'b1;
            cnt_rd_addr   = ring_q;
         end
         kfsc_pkg::ST_DROP_WR: begin
            cnt_cmd.wr_en = 1'b1;
            cnt_wr_addr   = ring_q;
            cnt_wr_data   = cnt_dec;
            head_in       = head_nx;
            fill_in       = fill_dec;
            dropped_in    = dropped_inc;
            if (!pre_ff) begin
               cur_cnt_in = drop_cur;
               if (more_after_drop) begin
                  ring_cmd.rd_en = 1'b1;
                  ring_rd_addr   = head_nx;
               end
            end
         end
         kfsc_pkg::ST_FINISH: begin
            if (rsp_free) begin
               total_in     = total_sat;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {total_sat, dropped_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kfsc_pkg::ST_IDLE;
         pre_ff       <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         dropped_ff   <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pre_ff       <= pre_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         dropped_ff   <= dropped_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= kfsc_pkg::K_RESET;
      end else if (csr_wr_en) begin
         k_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff      <= sym_in;
      cur_cnt_ff  <= cur_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== src/kfsc_count_store.sv =====
// per-symbol occurrence counts: synchronous memory with a registered read
// a valid bit per entry makes a cleared entry read as zero; uses kfsc_pkg

module kfsc_count_store #(
   parameter int SYMBOLS = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  kfsc_pkg::cnt_cmd_type        cmd,
   input  logic [$clog2(SYMBOLS)-1:0]   rd_addr,
   input  logic [$clog2(SYMBOLS)-1:0]   wr_addr,
   input  logic [kfsc_pkg::CNT_W-1:0]   wr_data,
   output logic [kfsc_pkg::CNT_W-1:0]   rd_data
);

   logic [kfsc_pkg::CNT_W-1:0] cnt_mem [SYMBOLS];
   logic [SYMBOLS-1:0]         valid_ff;
   logic [kfsc_pkg::CNT_W-1:0] rd_data_ff;
   logic                       rd_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         cnt_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= cnt_mem[rd_addr];
      end
   end

   // clearing all valid bits at once restarts every count
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== src/kfsc_window_ring.sv =====
// ring of window symbols: synchronous memory with a registered read
// contents are undefined until written; uses kfsc_pkg

module kfsc_window_ring #(
   parameter int SYMBOLS      = 256,
   parameter int WINDOW_DEPTH = 4096
) (
   input  logic                              clock,
   input  kfsc_pkg::ring_cmd_type            cmd,
   input  logic [$clog2(WINDOW_DEPTH)-1:0]   rd_addr,
   input  logic [$clog2(WINDOW_DEPTH)-1:0]   wr_addr,
   input  logic [$clog2(SYMBOLS)-1:0]        wr_data,
   output logic [$clog2(SYMBOLS)-1:0]        rd_data
);

   logic [$clog2(SYMBOLS)-1:0] ring_mem [WINDOW_DEPTH];
   logic [$clog2(SYMBOLS)-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/kfsc_checker.sv =====
// port-level checks for k_frequency_substring_counter, attached by bind
// depends on kfsc_pkg and the top level's ports

module kfsc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [kfsc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int END_W = kfsc_pkg::ENDING_W;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // the total includes the substrings ending at this symbol
   a_total_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[kfsc_pkg::RSP_DATA_W-1:END_W]
                     >= kfsc_pkg::TOTAL_W'(rsp_tdata[END_W-1:0]))
      else $error("running total below valid_ending_here");

   // one request in flight: no new request the cycle after one is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

endmodule

bind k_frequency_substring_counter kfsc_checker u_kfsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
